FILE: design/barr_pkg.sv
// ----------------------------------------------------------------------------
// barr_pkg
// Shared types, constants and codes of the batched-ack reassembly receiver.
// ----------------------------------------------------------------------------
package barr_pkg;

  localparam int MaxPackets = 64;
  localparam int MaxPayload = 16;
  localparam int MaxAck     = 16;

  localparam int StoreDepth = MaxPackets * MaxPayload;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int AckAw      = $clog2(MaxAck);
  localparam int MarkAw     = $clog2(MaxPackets);
  localparam int FillW      = $clog2(MaxAck + 1);

  localparam int SeqW    = 8;
  localparam int ByteW   = 8;
  localparam int AddrW   = 10;
  localparam int PifW    = 7;
  localparam int PayW    = 5;
  localparam int BatchW  = 5;
  localparam int OffW    = 5;
  localparam int SeenW   = 8;
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 2;
  localparam int ProdW   = SeqW + PayW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PACKETS = 2'd0,
    CFG_PAYLOAD = 2'd1,
    CFG_BATCH   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_PAYLOAD = 1'b0,
    CMD_READ    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SRC_IMM   = 2'd0,
    SRC_STORE = 2'd1,
    SRC_ACK   = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    ST_ITEM   = 2'd0,
    ST_ENTRY  = 2'd1,
    ST_STATUS = 2'd2
  } state_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic             last;
    logic             fc;
    src_e             src;
    logic [ByteW-1:0] imm;
    logic             ack_ok;
  } res_req_t;

endpackage

FILE: design/barr_ram.sv
// ----------------------------------------------------------------------------
// barr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module barr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/barr_out.sv
// ----------------------------------------------------------------------------
// barr_out
// Result stage: holds an issued result until its read data is in and the
// output register has room, then moves it into the output register.
// ----------------------------------------------------------------------------
module barr_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  barr_pkg::res_req_t        req_i,
  output logic                      issue_ok_o,
  input  logic [barr_pkg::ByteW-1:0] store_rdata_i,
  input  logic [barr_pkg::ByteW-1:0] ack_rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                result_kind_o,
  output logic [barr_pkg::ByteW-1:0] out_byte_o,
  output logic                      out_last_o,
  output logic                      file_complete_o
);

  barr_pkg::res_req_t        pend_q, pend_d;
  logic                      out_v_q, out_v_d;
  barr_pkg::kind_e           kind_q, kind_d;
  logic [barr_pkg::ByteW-1:0] byte_q, byte_d;
  logic                      last_q, last_d;
  logic                      fc_q, fc_d;
  logic                      pend_move;
  logic [barr_pkg::ByteW-1:0] pend_byte;

  assign pend_move  = pend_q.valid && (!out_v_q || !out_stall_i);
  assign issue_ok_o = !pend_q.valid || pend_move;

  always_comb begin
    case (pend_q.src)
      barr_pkg::SRC_IMM:   pend_byte = pend_q.imm;
      barr_pkg::SRC_STORE: pend_byte = store_rdata_i;
      barr_pkg::SRC_ACK:   pend_byte = pend_q.ack_ok ? ack_rdata_i : '0;
      default:             pend_byte = '0;
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    out_v_d = out_v_q;
    kind_d = kind_q;
    byte_d = byte_q;
    last_d = last_q;
    fc_d = fc_q;
    if (pend_move) begin
      out_v_d = 1'b1;
      kind_d = pend_q.kind;
      byte_d = pend_byte;
      last_d = pend_q.last;
      fc_d = pend_q.fc;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (req_i.valid) begin
      pend_d = req_i;
    end else if (pend_move) begin
      pend_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    last_q <= last_d;
    fc_q <= fc_d;
  end

  assign out_valid_o     = out_v_q;
  assign result_kind_o   = kind_q;
  assign out_byte_o      = byte_q;
  assign out_last_o      = last_q;
  assign file_complete_o = fc_q;

`ifndef ASSERT_OFF
  a_issue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> issue_ok_o)
    else $error("result issued while the result stage is full");
`endif

endmodule

FILE: design/barr_ctrl.sv
// ----------------------------------------------------------------------------
// barr_ctrl
// Item register and sequencer: stores payload bytes, keeps the received
// marks and the ack list, and issues results one per cycle unless stalled.
// ----------------------------------------------------------------------------
module barr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [barr_pkg::PifW-1:0]     pif_i,
  input  logic [barr_pkg::PayW-1:0]     pay_i,
  input  logic [barr_pkg::BatchW-1:0]   batch_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [barr_pkg::SeqW-1:0]     seq_number_i,
  input  logic [barr_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          end_of_packet_i,
  input  logic [barr_pkg::AddrW-1:0]    read_address_i,
  output logic                          st_we_o,
  output logic [barr_pkg::StoreAw-1:0]  st_waddr_o,
  output logic [barr_pkg::ByteW-1:0]    st_wdata_o,
  output logic                          st_re_o,
  output logic [barr_pkg::StoreAw-1:0]  st_raddr_o,
  output logic                          ack_we_o,
  output logic [barr_pkg::AckAw-1:0]    ack_waddr_o,
  output logic [barr_pkg::ByteW-1:0]    ack_wdata_o,
  output logic                          ack_re_o,
  output logic [barr_pkg::AckAw-1:0]    ack_raddr_o,
  output logic                          mk_we_o,
  output logic [barr_pkg::MarkAw-1:0]   mk_waddr_o,
  output logic                          mk_wdata_o,
  output logic                          mk_re_o,
  output logic [barr_pkg::MarkAw-1:0]   mk_raddr_o,
  input  logic                          mk_rdata_i,
  output barr_pkg::res_req_t            req_o,
  input  logic                          issue_ok_i
);

  logic                          s1_v_q, s1_v_d;
  barr_pkg::cmd_e                s1_cmd_q;
  logic [barr_pkg::SeqW-1:0]     s1_seq_q;
  logic [barr_pkg::ByteW-1:0]    s1_data_q;
  logic                          s1_eop_q;
  logic [barr_pkg::AddrW-1:0]    s1_raddr_q;
  logic                          mk_fwd_q;

  barr_pkg::state_e              state_q, state_d;
  logic [barr_pkg::AckAw-1:0]    idx_q, idx_d;
  logic                          clr_busy_q, clr_busy_d;
  logic [barr_pkg::MarkAw-1:0]   clr_idx_q, clr_idx_d;
  logic [barr_pkg::PifW-1:0]     distinct_q, distinct_d;
  logic [barr_pkg::FillW-1:0]    fill_q, fill_d;
  logic [barr_pkg::SeenW-1:0]    seen_q, seen_d;
  logic [barr_pkg::OffW-1:0]     offset_q, offset_d;
  logic [barr_pkg::MaxAck-1:0]   ack_ok_q, ack_ok_d;

  logic                          done;
  logic                          accept;
  logic                          in_range;
  logic                          byte_ok;
  logic                          store_ok;
  logic [barr_pkg::ProdW-1:0]    st_prod;
  logic [barr_pkg::FillW-1:0]    fill_inc;
  logic [barr_pkg::SeenW-1:0]    seen_inc;
  logic [barr_pkg::FillW-1:0]    batch_sat;
  logic                          frame;
  logic                          complete;
  logic                          entry_last;
  logic                          marked;
  logic                          mark_set;

  assign in_range = ({1'b0, s1_seq_q} < {1'b0, {(barr_pkg::SeqW - barr_pkg::PifW){1'b0}}, pif_i})
                 && (32'(s1_seq_q) < 32'(barr_pkg::MaxPackets));
  assign byte_ok  = offset_q < pay_i;
  assign st_prod  = barr_pkg::ProdW'(s1_seq_q) * barr_pkg::ProdW'(pay_i)
                  + barr_pkg::ProdW'(offset_q);
  assign store_ok = byte_ok && in_range
                 && (32'(st_prod) < 32'(barr_pkg::StoreDepth));

  assign fill_inc  = fill_q + 1'b1;
  assign seen_inc  = seen_q + 1'b1;
  assign batch_sat = (32'(batch_i) > 32'(barr_pkg::MaxAck))
                   ? barr_pkg::FillW'(barr_pkg::MaxAck) : barr_pkg::FillW'(batch_i);
  assign frame     = (fill_inc >= batch_sat)
                  || (seen_inc == barr_pkg::SeenW'(pif_i));
  assign complete  = distinct_q == pif_i;
  assign entry_last = barr_pkg::FillW'(idx_q) == batch_sat - 1'b1;
  assign marked    = mk_rdata_i || mk_fwd_q;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      barr_pkg::ST_ITEM: begin
        if (s1_v_q && s1_cmd_q == barr_pkg::CMD_PAYLOAD && s1_eop_q && issue_ok_i && frame) begin
          state_d = (batch_sat == '0) ? barr_pkg::ST_STATUS : barr_pkg::ST_ENTRY;
        end
      end
      barr_pkg::ST_ENTRY: begin
        if (issue_ok_i && entry_last) begin
          state_d = barr_pkg::ST_STATUS;
        end
      end
      barr_pkg::ST_STATUS: begin
        if (issue_ok_i) begin
          state_d = barr_pkg::ST_ITEM;
        end
      end
      default: state_d = barr_pkg::ST_ITEM;
    endcase
  end

  always_comb begin
    done = 1'b0;
    mark_set = 1'b0;
    req_o = '0;
    st_we_o = 1'b0;
    st_waddr_o = st_prod[barr_pkg::StoreAw-1:0];
    st_wdata_o = s1_data_q;
    st_re_o = 1'b0;
    st_raddr_o = s1_raddr_q[barr_pkg::StoreAw-1:0];
    ack_we_o = 1'b0;
    ack_waddr_o = fill_q[barr_pkg::AckAw-1:0];
    ack_wdata_o = s1_seq_q;
    ack_re_o = 1'b0;
    ack_raddr_o = idx_q;
    idx_d = idx_q;
    distinct_d = distinct_q;
    fill_d = fill_q;
    seen_d = seen_q;
    offset_d = offset_q;
    ack_ok_d = ack_ok_q;
    case (state_q)
      barr_pkg::ST_ITEM: begin
        idx_d = '0;
        if (s1_v_q) begin
          if (s1_cmd_q == barr_pkg::CMD_READ) begin
            if (issue_ok_i) begin
              done = 1'b1;
              st_re_o = 1'b1;
              req_o.valid = 1'b1;
              req_o.kind = barr_pkg::KIND_READ;
              req_o.last = 1'b1;
              req_o.fc = complete;
              req_o.src = barr_pkg::SRC_STORE;
            end
          end else if (!s1_eop_q) begin
            done = 1'b1;
            st_we_o = store_ok;
            if (byte_ok) begin
              offset_d = offset_q + 1'b1;
            end
          end else if (issue_ok_i) begin
            st_we_o = store_ok;
            offset_d = '0;
            if (in_range && !marked) begin
              mark_set = 1'b1;
              distinct_d = distinct_q + 1'b1;
            end
            ack_we_o = 1'b1;
            ack_ok_d[fill_q[barr_pkg::AckAw-1:0]] = 1'b1;
            seen_d = seen_inc;
            req_o.valid = 1'b1;
            req_o.fc = distinct_d == pif_i;
            if (frame) begin
              fill_d = '0;
              req_o.kind = barr_pkg::KIND_ACK;
              req_o.src = barr_pkg::SRC_IMM;
              req_o.imm = barr_pkg::ByteW'(fill_inc);
            end else begin
              done = 1'b1;
              fill_d = (32'(fill_inc) > 32'(barr_pkg::MaxAck - 1))
                     ? barr_pkg::FillW'(barr_pkg::MaxAck - 1) : fill_inc;
              req_o.kind = barr_pkg::KIND_STATUS;
              req_o.last = 1'b1;
              req_o.src = barr_pkg::SRC_IMM;
              req_o.imm = s1_seq_q;
            end
          end
        end
      end
      barr_pkg::ST_ENTRY: begin
        if (issue_ok_i) begin
          ack_re_o = 1'b1;
          idx_d = idx_q + 1'b1;
          req_o.valid = 1'b1;
          req_o.kind = barr_pkg::KIND_ACK;
          req_o.fc = complete;
          req_o.src = barr_pkg::SRC_ACK;
          req_o.ack_ok = ack_ok_q[idx_q];
        end
      end
      barr_pkg::ST_STATUS: begin
        if (issue_ok_i) begin
          done = 1'b1;
          req_o.valid = 1'b1;
          req_o.kind = barr_pkg::KIND_STATUS;
          req_o.last = 1'b1;
          req_o.fc = complete;
          req_o.src = barr_pkg::SRC_IMM;
          req_o.imm = s1_seq_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o = clr_busy_q || (s1_v_q && !done);
  assign accept     = in_valid_i && !in_stall_o;

  assign mk_we_o    = clr_busy_q || mark_set;
  assign mk_waddr_o = clr_busy_q ? clr_idx_q : s1_seq_q[barr_pkg::MarkAw-1:0];
  assign mk_wdata_o = !clr_busy_q;
  assign mk_re_o    = accept;
  assign mk_raddr_o = seq_number_i[barr_pkg::MarkAw-1:0];

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = 1'b1;
    end else if (done) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      state_q <= barr_pkg::ST_ITEM;
      idx_q <= '0;
      clr_busy_q <= 1'b1;
      clr_idx_q <= '0;
      distinct_q <= '0;
      fill_q <= '0;
      seen_q <= '0;
      offset_q <= '0;
      ack_ok_q <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      state_q <= state_d;
      idx_q <= idx_d;
      clr_busy_q <= clr_busy_d;
      clr_idx_q <= clr_idx_d;
      distinct_q <= distinct_d;
      fill_q <= fill_d;
      seen_q <= seen_d;
      offset_q <= offset_d;
      ack_ok_q <= ack_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= barr_pkg::cmd_e'(command_i);
      s1_seq_q <= seq_number_i;
      s1_data_q <= data_byte_i;
      s1_eop_q <= end_of_packet_i;
      s1_raddr_q <= read_address_i;
      mk_fwd_q <= mark_set
               && (s1_seq_q[barr_pkg::MarkAw-1:0] == seq_number_i[barr_pkg::MarkAw-1:0]);
    end
  end

`ifndef ASSERT_OFF
  a_seq_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != barr_pkg::ST_ITEM |-> s1_v_q)
    else $error("sequencer running without an item");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(barr_pkg::MaxAck - 1))
    else $error("ack fill beyond list");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (in_stall_o && !s1_v_q))
    else $error("item taken while the marks are being cleared");

  a_store_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_we_o && st_re_o))
    else $error("store read and write in one cycle");
`endif

endmodule

FILE: design/batched_ack_reassembly_receiver_unit.sv
// ----------------------------------------------------------------------------
// batched_ack_reassembly_receiver_unit
// Packet reassembly receiver with batched ack frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one item per handshake:
// a payload byte tagged with its sequence number, or a read command.
// Output channel (out_valid_o / out_stall_i) carries result items: ack frame
// bytes, one packet status per packet end, and read data.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i
// while the block is idle.
// An item's results pass from the input register through the result stage
// into the output register; a new item is taken as the last one finishes.
// A payload byte, a read or a packet end closing no ack frame gives at most
// one result; a frame-closing one gives the count byte, min(ack_batch, 16)
// entries and the status, as the result stage and the ack memory read port deliver one result a cycle unless stalled.
// Reset clears all control state and the ack list valid bits at once; the
// received marks memory is then cleared entry by entry, with in_stall_o high.
// The reassembly store holds no reset value.
// When the receiver stalls, results wait in the result stage and then the
// input register, and in_stall_o rises.
// ----------------------------------------------------------------------------
module batched_ack_reassembly_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [barr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [barr_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [barr_pkg::SeqW-1:0]      seq_number_i,
  input  logic [barr_pkg::ByteW-1:0]     data_byte_i,
  input  logic                           end_of_packet_i,
  input  logic [barr_pkg::AddrW-1:0]     read_address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     result_kind_o,
  output logic [barr_pkg::ByteW-1:0]     out_byte_o,
  output logic                           out_last_o,
  output logic                           file_complete_o
);

  logic [barr_pkg::PifW-1:0]    pif_q, pif_d;
  logic [barr_pkg::PayW-1:0]    pay_q, pay_d;
  logic [barr_pkg::BatchW-1:0]  batch_q, batch_d;

  logic                         st_we;
  logic [barr_pkg::StoreAw-1:0] st_waddr;
  logic [barr_pkg::ByteW-1:0]   st_wdata;
  logic                         st_re;
  logic [barr_pkg::StoreAw-1:0] st_raddr;
  logic [barr_pkg::ByteW-1:0]   st_rdata;
  logic                         ack_we;
  logic [barr_pkg::AckAw-1:0]   ack_waddr;
  logic [barr_pkg::ByteW-1:0]   ack_wdata;
  logic                         ack_re;
  logic [barr_pkg::AckAw-1:0]   ack_raddr;
  logic [barr_pkg::ByteW-1:0]   ack_rdata;
  logic                         mk_we;
  logic [barr_pkg::MarkAw-1:0]  mk_waddr;
  logic                         mk_wdata;
  logic                         mk_re;
  logic [barr_pkg::MarkAw-1:0]  mk_raddr;
  logic                         mk_rdata;
  barr_pkg::res_req_t           req;
  logic                         issue_ok;

  always_comb begin
    pif_d = pif_q;
    pay_d = pay_q;
    batch_d = batch_q;
    if (cfg_we_i) begin
      case (barr_pkg::cfg_idx_e'(cfg_index_i))
        barr_pkg::CFG_PACKETS: pif_d = cfg_wdata_i[barr_pkg::PifW-1:0];
        barr_pkg::CFG_PAYLOAD: pay_d = cfg_wdata_i[barr_pkg::PayW-1:0];
        barr_pkg::CFG_BATCH:   batch_d = cfg_wdata_i[barr_pkg::BatchW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pif_q <= barr_pkg::PifW'(1);
      pay_q <= barr_pkg::PayW'(1);
      batch_q <= barr_pkg::BatchW'(1);
    end else begin
      pif_q <= pif_d;
      pay_q <= pay_d;
      batch_q <= batch_d;
    end
  end

  barr_ram #(
    .Width(barr_pkg::ByteW),
    .Depth(barr_pkg::StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  barr_ram #(
    .Width(barr_pkg::ByteW),
    .Depth(barr_pkg::MaxAck)
  ) u_ack (
    .clk_i  (clk_i),
    .we_i   (ack_we),
    .waddr_i(ack_waddr),
    .wdata_i(ack_wdata),
    .re_i   (ack_re),
    .raddr_i(ack_raddr),
    .rdata_o(ack_rdata)
  );

  barr_ram #(
    .Width(1),
    .Depth(barr_pkg::MaxPackets)
  ) u_marks (
    .clk_i  (clk_i),
    .we_i   (mk_we),
    .waddr_i(mk_waddr),
    .wdata_i(mk_wdata),
    .re_i   (mk_re),
    .raddr_i(mk_raddr),
    .rdata_o(mk_rdata)
  );

  barr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pif_i          (pif_q),
    .pay_i          (pay_q),
    .batch_i        (batch_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .seq_number_i   (seq_number_i),
    .data_byte_i    (data_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .read_address_i (read_address_i),
    .st_we_o        (st_we),
    .st_waddr_o     (st_waddr),
    .st_wdata_o     (st_wdata),
    .st_re_o        (st_re),
    .st_raddr_o     (st_raddr),
    .ack_we_o       (ack_we),
    .ack_waddr_o    (ack_waddr),
    .ack_wdata_o    (ack_wdata),
    .ack_re_o       (ack_re),
    .ack_raddr_o    (ack_raddr),
    .mk_we_o        (mk_we),
    .mk_waddr_o     (mk_waddr),
    .mk_wdata_o     (mk_wdata),
    .mk_re_o        (mk_re),
    .mk_raddr_o     (mk_raddr),
    .mk_rdata_i     (mk_rdata),
    .req_o          (req),
    .issue_ok_i     (issue_ok)
  );

  barr_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .issue_ok_o     (issue_ok),
    .store_rdata_i  (st_rdata),
    .ack_rdata_i    (ack_rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .file_complete_o(file_complete_o)
  );

endmodule
